// ===== rtl/rbu_pkg.sv =====
package rbu_pkg;

	localparam int CFG_W      = 5;   // capacity register
	localparam int ACT_W      = 2;
	localparam int ST_W       = 2;
	localparam int OCC_W      = 5;
	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;
	localparam int CAP_RESET  = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_UNDO  = 2'd2
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== rtl/ring_buffer_with_undo_last_write.sv =====
// Channel | Direction | Handshake           | Payload
// in      | in        | in_valid / in_ready | action, write_value
// out     | out       | out_valid/out_ready | status, read_value, occupancy
// cfg     | in        | cfg_we (no wait)    | cfg_wdata -> capacity
//
// One item per clock while out_ready allows: the pointer and count update is a
// single short step done as the item is taken, which also loads the result register.
// The storage is a memory with one write and one registered read port per cycle.
// The next item is taken while a result waits, as long as out_ready is high.
// If out_ready is low with a result held, in_ready drops until that result goes.
// arst_n clears pointers, count, capacity (back to 16) and the result valid flag;
// the storage words are not cleared.
module ring_buffer_with_undo_last_write #(
	parameter int DEPTH      = rbu_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbu_pkg::DATA_W_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [rbu_pkg::CFG_W-1:0]  cfg_wdata,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rbu_pkg::ACT_W-1:0]  action,
	input  logic [DATA_WIDTH-1:0]      write_value,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rbu_pkg::ST_W-1:0]   status,
	output logic [DATA_WIDTH-1:0]      read_value,
	output logic [rbu_pkg::OCC_W-1:0]  occupancy
);
	import rbu_pkg::*;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// capacity register is 5 bits, so the effective capacity tops out at 31
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	// wide enough for index + 1 and for the capacity
	localparam int SUM_W   = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

	// --- state ---------------------------------------------------------------
	logic [CFG_W-1:0]       capacity_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [IDX_W-1:0]       wr_idx_q;
	logic [OCC_W-1:0]       count_q;
	logic [DATA_WIDTH-1:0]  storage [DEPTH];

	// --- result register -----------------------------------------------------
	logic                   out_valid_s1;
	status_t                status_s1;
	logic                   rd_ok_s1;
	logic [DATA_WIDTH-1:0]  rd_data_s1;
	logic [OCC_W-1:0]       occ_s1;

	// --- next-state logic ----------------------------------------------------
	logic                   accept;
	logic [CFG_W-1:0]       cap_eff;
	logic                   is_empty;
	logic                   is_full;
	logic                   do_write;
	logic                   do_read;
	status_t                status_d;
	logic [IDX_W-1:0]       rd_idx_d;
	logic [IDX_W-1:0]       wr_idx_d;
	logic [OCC_W-1:0]       count_d;

	// step an index forward, wrapping at the capacity
	function automatic logic [IDX_W-1:0] idx_advance(
		input logic [IDX_W-1:0] idx,
		input logic [CFG_W-1:0] cap
	);
		logic [SUM_W-1:0] nxt;
		nxt = SUM_W'(idx) + SUM_W'(1);
		return (nxt >= SUM_W'(cap)) ? '0 : IDX_W'(nxt);
	endfunction

	// step an index back; from zero, or from beyond the capacity, go to the top
	function automatic logic [IDX_W-1:0] idx_retreat(
		input logic [IDX_W-1:0] idx,
		input logic [CFG_W-1:0] cap
	);
		if (idx == '0 || SUM_W'(idx) > SUM_W'(cap))
			return IDX_W'(cap - CFG_W'(1));
		return idx - IDX_W'(1);
	endfunction

	assign in_ready = !out_valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// zero acts as one, anything above the storage depth acts as the depth
	always_comb begin
		if (capacity_q == '0)
			cap_eff = CFG_W'(1);
		else if (capacity_q > CFG_W'(CAP_MAX))
			cap_eff = CFG_W'(CAP_MAX);
		else
			cap_eff = capacity_q;
	end

	assign is_empty = (count_q == '0);
	assign is_full  = (SUM_W'(count_q) >= SUM_W'(cap_eff));

	always_comb begin
		status_d = ST_OK;
		do_write = 1'b0;
		do_read  = 1'b0;
		rd_idx_d = rd_idx_q;
		wr_idx_d = wr_idx_q;
		count_d  = count_q;
		case (action)
			ACT_WRITE: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					do_write = 1'b1;
					wr_idx_d = idx_advance(wr_idx_q, cap_eff);
					count_d  = count_q + OCC_W'(1);
				end
			end
			ACT_READ: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					do_read  = 1'b1;
					rd_idx_d = idx_advance(rd_idx_q, cap_eff);
					count_d  = count_q - OCC_W'(1);
				end
			end
			ACT_UNDO: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					wr_idx_d = idx_retreat(wr_idx_q, cap_eff);
					count_d  = count_q - OCC_W'(1);
				end
			end
			default: begin
				// unused action code: nothing changes, status ok
				status_d = ST_OK;
			end
		endcase
	end

	// --- control registers ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CFG_W'(CAP_RESET);
			rd_idx_q     <= '0;
			wr_idx_q     <= '0;
			count_q      <= '0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we)
				capacity_q <= cfg_wdata;
			if (accept) begin
				rd_idx_q <= rd_idx_d;
				wr_idx_q <= wr_idx_d;
				count_q  <= count_d;
			end
			if (accept)
				out_valid_s1 <= 1'b1;
			else if (out_ready)
				out_valid_s1 <= 1'b0;
		end
	end

	// --- storage: one write, one registered read per cycle -------------------
	// The read port always looks at the oldest word; the item's own write can
	// never target a word it reads, so read-before-write is what is wanted.
	always_ff @(posedge clk) begin
		if (accept && do_write)
			storage[wr_idx_q] <= write_value;
		if (accept)
			rd_data_s1 <= storage[rd_idx_q];
	end

	// --- result payload ------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			rd_ok_s1  <= do_read;
			occ_s1    <= count_d;
		end
	end

	assign out_valid  = out_valid_s1;
	assign status     = status_s1;
	assign read_value = rd_ok_s1 ? rd_data_s1 : '0;
	assign occupancy  = occ_s1;

endmodule

// ===== rtl/rbu_checker.sv =====
module rbu_checker #(
	parameter int DATA_WIDTH = rbu_pkg::DATA_W_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rbu_pkg::ST_W-1:0]   status,
	input logic [DATA_WIDTH-1:0]      read_value,
	input logic [rbu_pkg::OCC_W-1:0]  occupancy
);
	import rbu_pkg::*;

	// a held result must not change under back-pressure
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(read_value) && $stable(occupancy))
		else $error("result changed while stalled");

	// input is only held off by a stalled result
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without a stalled result");

	// an empty report means nothing stored and no data returned
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0 && read_value == '0)
		else $error("empty status with data or occupancy");

	// a refused write leaves a non-empty buffer and returns no data
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy != '0 && read_value == '0)
		else $error("full status with empty buffer or data");

endmodule

bind ring_buffer_with_undo_last_write rbu_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_rbu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.read_value (read_value),
	.occupancy  (occupancy)
);
